/* rtl/core/typed_integer_alu_macros.svh */
// Assertion helpers used by the checker file.
// Each expects signals named clock and reset in the scope of use.
`ifndef TYPED_INTEGER_ALU_MACROS_SVH
`define TYPED_INTEGER_ALU_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TIA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TIA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tia_pkg.sv */
package tia_pkg;

   localparam int DataWidth = 64;

   typedef logic [DataWidth-1:0] data_type;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL_LO = 4'd2,
      OP_SSMULH = 4'd3,
      OP_UUMULH = 4'd4,
      OP_SUMULH = 4'd5,
      OP_SHL    = 4'd6,
      OP_SHR    = 4'd7,
      OP_SAR    = 4'd8,
      OP_OR     = 4'd9,
      OP_AND    = 4'd10,
      OP_XOR    = 4'd11,
      OP_UMAX   = 4'd12,
      OP_MAX    = 4'd13,
      OP_UMIN   = 4'd14,
      OP_MIN    = 4'd15
   } mode_type;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_sel_type;

   // Number of bits in the selected width.
   function automatic logic [6:0] width_bits(input width_sel_type w);
      logic [6:0] bits;
      unique case (w)
         WIDTH_8:  bits = 7'd8;
         WIDTH_16: bits = 7'd16;
         WIDTH_32: bits = 7'd32;
         WIDTH_64: bits = 7'd64;
         default:  bits = 7'd64;
      endcase
      return bits;
   endfunction

   function automatic data_type width_mask(input width_sel_type w);
      data_type m;
      unique case (w)
         WIDTH_8:  m = {56'd0, {8{1'b1}}};
         WIDTH_16: m = {48'd0, {16{1'b1}}};
         WIDTH_32: m = {32'd0, {32{1'b1}}};
         WIDTH_64: m = {64{1'b1}};
         default:  m = {64{1'b1}};
      endcase
      return m;
   endfunction

   function automatic data_type widen_signed(input data_type v, input width_sel_type w);
      data_type r;
      unique case (w)
         WIDTH_8:  r = {{56{v[7]}}, v[7:0]};
         WIDTH_16: r = {{48{v[15]}}, v[15:0]};
         WIDTH_32: r = {{32{v[31]}}, v[31:0]};
         WIDTH_64: r = v;
         default:  r = v;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/tia_if.sv */
// Request channel: opcode, width and two operands.
interface tia_req_if;
   logic                     valid;
   logic                     ready;
   tia_pkg::mode_type        mode;
   tia_pkg::width_sel_type   width_sel;
   tia_pkg::data_type        operand_a;
   tia_pkg::data_type        operand_b;

   modport source (output valid, output mode, output width_sel, output operand_a,
                   output operand_b, input ready);
   modport sink   (input valid, input mode, input width_sel, input operand_a,
                   input operand_b, output ready);
endinterface

// Response channel: zero-extended result.
interface tia_rsp_if;
   logic                valid;
   logic                ready;
   tia_pkg::data_type   result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

/* rtl/core/typed_integer_alu.sv */
// Typed integer ALU: add, sub, low and high multiplies, shifts, logic ops and
// min/max at 8, 16, 32 or 64 bits, with the result zero-extended to 64 bits.
// The unit takes one request per clock unless a stalled response holds the
// pipe. A result passes the input register, the partial-product register, the
// partial-sum register and the result register before the response channel
// presents it. The four-register depth is set by
// the multiplier, which is built from four partial products of at most 33x33
// bits whose sum is finished in front of the result register. A stalled
// response holds every stage at once; req ready is high whenever the result
// register is empty or being taken in that cycle.
module typed_integer_alu (
   input logic       clock,
   input logic       reset,
   tia_req_if.sink   req_if,
   tia_rsp_if.source rsp_if
);
   import tia_pkg::*;

   typedef enum logic [1:0] {
      KIND_ALU    = 2'd0,
      KIND_MUL_LO = 2'd1,
      KIND_MUL_HI = 2'd2
   } kind_type;

   // Whole pipe advances unless the result register holds an untaken result.
   logic advance;

   // Stage 1: input register.
   logic          s1_valid_ff;
   mode_type      s1_mode_ff;
   width_sel_type s1_width_ff;
   data_type      s1_a_ff;
   data_type      s1_b_ff;

   // Stage 2: partial products and the non-multiply result.
   logic                s2_valid_ff;
   kind_type            s2_kind_ff;
   width_sel_type       s2_width_ff;
   data_type            s2_alu_ff;
   logic [63:0]         s2_ll_ff;
   logic signed [65:0]  s2_lh_ff;
   logic signed [65:0]  s2_hl_ff;
   logic [63:0]         s2_hh_ff;

   // Stage 3: middle terms folded.
   logic          s3_valid_ff;
   kind_type      s3_kind_ff;
   width_sel_type s3_width_ff;
   data_type      s3_alu_ff;
   logic [63:0]   s3_ll_ff;
   logic [66:0]   s3_mid_ff;
   logic [63:0]   s3_hh_ff;

   // Result register.
   logic     rsp_valid_ff;
   data_type rsp_result_ff;

   // Stage 1 -> 2 logic.
   data_type           a_t, b_t, a_sx, b_sx;
   logic               amount_big;
   logic [5:0]         amount;
   logic               a_signed, b_signed;
   logic [64:0]        a_ext, b_ext;
   data_type           s2_alu_in;
   kind_type           s2_kind_in;
   logic [63:0]        s2_ll_in;
   logic signed [65:0] s2_lh_in, s2_hl_in, s2_hh_in;

   // Stage 2 -> 3 and 3 -> result logic.
   logic [66:0]  s3_mid_in;
   logic [127:0] product;
   data_type     prod_high;
   data_type     rsp_result_in;

   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.result = rsp_result_ff;

   // Truncate and extend operands to the selected width.
   always_comb begin
      a_t        = s1_a_ff & width_mask(s1_width_ff);
      b_t        = s1_b_ff & width_mask(s1_width_ff);
      a_sx       = widen_signed(a_t, s1_width_ff);
      b_sx       = widen_signed(b_t, s1_width_ff);
      amount_big = (b_t >= data_type'(width_bits(s1_width_ff)));
      amount     = b_t[5:0];
   end

   // Non-multiply operations. Out-of-range shift amounts give zero, or sign
   // fill for the arithmetic shift.
   always_comb begin
      s2_kind_in = KIND_ALU;
      s2_alu_in  = '0;
      unique case (s1_mode_ff)
         OP_ADD:    s2_alu_in = a_t + b_t;
         OP_SUB:    s2_alu_in = a_t - b_t;
         OP_MUL_LO: s2_kind_in = KIND_MUL_LO;
         OP_SSMULH: s2_kind_in = KIND_MUL_HI;
         OP_UUMULH: s2_kind_in = KIND_MUL_HI;
         OP_SUMULH: s2_kind_in = KIND_MUL_HI;
         OP_SHL:    s2_alu_in = amount_big ? '0 : (a_t << amount);
         OP_SHR:    s2_alu_in = amount_big ? '0 : (a_t >> amount);
         OP_SAR:    s2_alu_in = amount_big ? {64{a_sx[63]}}
                                           : data_type'($signed(a_sx) >>> amount);
         OP_OR:     s2_alu_in = a_t | b_t;
         OP_AND:    s2_alu_in = a_t & b_t;
         OP_XOR:    s2_alu_in = a_t ^ b_t;
         OP_UMAX:   s2_alu_in = (a_t > b_t) ? a_t : b_t;
         OP_MAX:    s2_alu_in = ($signed(a_sx) > $signed(b_sx)) ? a_t : b_t;
         OP_UMIN:   s2_alu_in = (a_t < b_t) ? a_t : b_t;
         OP_MIN:    s2_alu_in = ($signed(a_sx) < $signed(b_sx)) ? a_t : b_t;
         default:   s2_alu_in = '0;
      endcase
   end

   // Extend to 65 bits signed as the opcode says, then split into a 32-bit
   // unsigned low part and a 33-bit signed high part per operand.
   always_comb begin
      a_signed = (s1_mode_ff == OP_SSMULH) || (s1_mode_ff == OP_SUMULH);
      b_signed = (s1_mode_ff == OP_SSMULH);
      a_ext    = a_signed ? {a_sx[63], a_sx} : {1'b0, a_t};
      b_ext    = b_signed ? {b_sx[63], b_sx} : {1'b0, b_t};
      s2_ll_in = a_ext[31:0] * b_ext[31:0];
      s2_lh_in = $signed({1'b0, a_ext[31:0]}) * $signed(b_ext[64:32]);
      s2_hl_in = $signed(a_ext[64:32]) * $signed({1'b0, b_ext[31:0]});
      s2_hh_in = $signed(a_ext[64:32]) * $signed(b_ext[64:32]);
   end

   assign s3_mid_in = {s2_lh_ff[65], s2_lh_ff} + {s2_hl_ff[65], s2_hl_ff};

   // Finish the product modulo 2^128 and pick the requested half.
   always_comb begin
      product = {s3_hh_ff, s3_ll_ff} + {{29{s3_mid_ff[66]}}, s3_mid_ff, 32'd0};
      unique case (s3_width_ff)
         WIDTH_8:  prod_high = product[71:8];
         WIDTH_16: prod_high = product[79:16];
         WIDTH_32: prod_high = product[95:32];
         WIDTH_64: prod_high = product[127:64];
         default:  prod_high = product[127:64];
      endcase
      unique case (s3_kind_ff)
         KIND_ALU:    rsp_result_in = s3_alu_ff;
         KIND_MUL_LO: rsp_result_in = product[63:0];
         KIND_MUL_HI: rsp_result_in = prod_high;
         default:     rsp_result_in = s3_alu_ff;
      endcase
      rsp_result_in = rsp_result_in & width_mask(s3_width_ff);
   end

   // Valid bits: clear on reset, advance as one.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_if.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Payload: hold while stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff    <= req_if.mode;
         s1_width_ff   <= req_if.width_sel;
         s1_a_ff       <= req_if.operand_a;
         s1_b_ff       <= req_if.operand_b;

         s2_kind_ff    <= s2_kind_in;
         s2_width_ff   <= s1_width_ff;
         s2_alu_ff     <= s2_alu_in;
         s2_ll_ff      <= s2_ll_in;
         s2_lh_ff      <= s2_lh_in;
         s2_hl_ff      <= s2_hl_in;
         s2_hh_ff      <= s2_hh_in[63:0];

         s3_kind_ff    <= s2_kind_ff;
         s3_width_ff   <= s2_width_ff;
         s3_alu_ff     <= s2_alu_ff;
         s3_ll_ff      <= s2_ll_ff;
         s3_mid_ff     <= s3_mid_in;
         s3_hh_ff      <= s2_hh_ff;

         rsp_result_ff <= rsp_result_in;
      end
   end

endmodule

/* rtl/core/tia_checker.sv */
`include "typed_integer_alu_macros.svh"

module tia_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tia_pkg::data_type rsp_result
);
   import tia_pkg::*;

   `TIA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result), "stalled response changed")
   `TIA_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "request blocked with empty output")
   `TIA_ASSERT_NOW(a_ready_when_taken, rsp_ready, req_ready, "request blocked while output drains")
   `TIA_ASSERT_NOW(a_empty_after_reset, $past(reset), !rsp_valid, "response valid right after reset")

endmodule

bind typed_integer_alu tia_checker u_tia_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_result (rsp_if.result)
);
